// ----- rtl/mqsb_pkg.sv -----
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared widths, operation codes and status codes of the shared-buffer
// multi-queue unit.
// ----------------------------------------------------------------------------
`default_nettype none

package mqsb_pkg;

  localparam int DATA_W     = 32;
  localparam int STATUS_W   = 2;

  localparam int DEPTH_DEF  = 16;
  localparam int QUEUES_DEF = 4;

  // operation codes
  localparam logic FUNC_ENQ = 1'b0;
  localparam logic FUNC_DEQ = 1'b1;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_UNDERFLOW = 2'd2;

  // word returned by a dequeue from an empty queue
  localparam logic signed [DATA_W-1:0] DATA_EMPTY = -32'sd1;

endpackage : mqsb_pkg

`default_nettype wire

// ----- rtl/mqsb_qptr_mem.sv -----
// ----------------------------------------------------------------------------
// mqsb_qptr_mem
// Queue pointer store: head and tail slot of each queue in one synchronous
// memory, with a written bit per queue so that an untouched queue reads empty.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_qptr_mem #(
  parameter int QUEUES = 4,
  parameter int PTR_W  = 5,
  parameter int QID_W  = 2,
  parameter int DEPTH  = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [QID_W-1:0] rd_addr,
  output logic [PTR_W-1:0] head_rd,
  output logic [PTR_W-1:0] tail_rd,
  input  logic             we,
  input  logic [QID_W-1:0] waddr,
  input  logic [PTR_W-1:0] whead,
  input  logic [PTR_W-1:0] wtail
);
  import mqsb_pkg::*;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  logic [2*PTR_W-1:0] qptr_mem_r [QUEUES];
  logic [QUEUES-1:0]  qv_r;
  logic [QUEUES-1:0]  qv_nxt;
  logic [2*PTR_W-1:0] ent_r;
  logic               ent_v_r;

  always_comb begin
    qv_nxt = qv_r;
    if (we) begin
      qv_nxt[waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qv_r <= '0;
    end else begin
      qv_r <= qv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      qptr_mem_r[waddr] <= {whead, wtail};
    end
    if (rd_en) begin
      ent_r   <= qptr_mem_r[rd_addr];
      ent_v_r <= qv_r[rd_addr];
    end
  end

  // a queue never written reads as empty
  assign head_rd = ent_v_r ? ent_r[2*PTR_W-1:PTR_W] : NIL;
  assign tail_rd = ent_v_r ? ent_r[PTR_W-1:0]       : NIL;

endmodule : mqsb_qptr_mem

`default_nettype wire

// ----- rtl/mqsb_slot_mem.sv -----
// ----------------------------------------------------------------------------
// mqsb_slot_mem
// Slot store: data word and next-slot link of every slot, one shared read
// port, with a fill count standing in for the initial sequential link chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mqsb_slot_mem #(
  parameter int DEPTH  = 16,
  parameter int PTR_W  = 5,
  parameter int SLOT_W = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              rd_en,
  input  logic [SLOT_W-1:0]                 rd_addr,
  output logic [PTR_W-1:0]                  link_rd,
  output logic signed [mqsb_pkg::DATA_W-1:0] data_rd,
  input  logic                              claim_en,
  input  logic [SLOT_W-1:0]                 claim_slot,
  input  logic                              link_we,
  input  logic [SLOT_W-1:0]                 link_waddr,
  input  logic [PTR_W-1:0]                  link_wdata,
  input  logic                              data_we,
  input  logic [SLOT_W-1:0]                 data_waddr,
  input  logic signed [mqsb_pkg::DATA_W-1:0] data_wdata
);
  import mqsb_pkg::*;

  localparam logic [PTR_W-1:0] NIL = PTR_W'(DEPTH);

  logic [PTR_W-1:0]         link_mem_r [DEPTH];
  logic signed [DATA_W-1:0] data_mem_r [DEPTH];
  logic [PTR_W-1:0]         fill_r;
  logic [PTR_W-1:0]         fill_nxt;
  logic [PTR_W-1:0]         link_raw_r;
  logic [PTR_W-1:0]         succ_r;
  logic                     fresh_r;
  logic signed [DATA_W-1:0] data_rd_r;

  // slots at or above the fill count were never handed out: their link is
  // the next slot up, null past the last one
  always_comb begin
    fill_nxt = fill_r;
    if (claim_en && (PTR_W'(claim_slot) == fill_r)) begin
      fill_nxt = fill_r + PTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem_r[link_waddr] <= link_wdata;
    end
    if (data_we) begin
      data_mem_r[data_waddr] <= data_wdata;
    end
    if (rd_en) begin
      link_raw_r <= link_mem_r[rd_addr];
      data_rd_r  <= data_mem_r[rd_addr];
      fresh_r    <= (PTR_W'(rd_addr) >= fill_r);
      succ_r     <= PTR_W'(rd_addr) + PTR_W'(1);
    end
  end

  // any stored index past the last slot counts as null
  assign link_rd = fresh_r ? succ_r : ((link_raw_r >= NIL) ? NIL : link_raw_r);
  assign data_rd = data_rd_r;

endmodule : mqsb_slot_mem

`default_nettype wire

// ----- rtl/multi_queue_shared_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit
// QUEUES FIFO queues kept as linked lists in one shared buffer of DEPTH slots.
// ----------------------------------------------------------------------------
// Each input transaction is an enqueue or a dequeue on one queue and gives
// exactly one result transaction. An enqueue takes the slot at the head of the
// free list, appends it to the queue's tail and stores the word; with no free
// slot (or a queue number at or past QUEUES) it reports overflow with data 0. A
// dequeue unlinks the queue's head slot, returns its word and pushes the slot
// onto the free list; on an empty queue (or one at or past QUEUES) it
// reports underflow with data -1. The block handles one transaction at a
// time: an enqueue, or a dequeue that underflows, passes S_EXEC before its
// result is registered; a dequeue that finds an entry passes S_EXEC, then
// S_DEQ. The steps follow the read of the queue pointer memory and, for such
// a dequeue, the dependent read of the slot store at the head slot. The
// result sits in an output register, so a new transaction is accepted while
// the previous result is still waiting to be taken; the block only holds
// in_stall while it is working on a transaction. The slot links need no
// clearing pass after reset: a fill count stands in for the initial chain.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_shared_buffer_unit #(
  parameter int DEPTH  = mqsb_pkg::DEPTH_DEF,
  parameter int QUEUES = mqsb_pkg::QUEUES_DEF,
  localparam int QID_W = (QUEUES > 1) ? $clog2(QUEUES) : 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_func,
  input  logic [QID_W-1:0]                   in_queue_id,
  input  logic signed [mqsb_pkg::DATA_W-1:0] in_data_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [mqsb_pkg::DATA_W-1:0] out_data_out,
  output logic [mqsb_pkg::STATUS_W-1:0]      out_status
);
  import mqsb_pkg::*;

  localparam int PTR_W  = $clog2(DEPTH + 1);   // slot index or null
  localparam int SLOT_W = $clog2(DEPTH);       // slot index only
  localparam int QCMP_W = QID_W + 1;

  localparam logic [PTR_W-1:0]  NIL      = PTR_W'(DEPTH);
  localparam logic [QCMP_W-1:0] QUEUES_V = QCMP_W'(QUEUES);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;   // waiting for a request
  localparam logic [1:0] S_EXEC = 2'd1;   // queue pointers read back
  localparam logic [1:0] S_DEQ  = 2'd2;   // head slot read back (dequeue)

  logic [1:0]               state_r, state_nxt;
  logic                     func_r;
  logic [QID_W-1:0]         q_r;
  logic signed [DATA_W-1:0] word_r;
  logic                     qok_r;
  logic [PTR_W-1:0]         free_head_r, free_head_nxt;
  logic [PTR_W-1:0]         h_r, h_nxt;
  logic [PTR_W-1:0]         t_r, t_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [DATA_W-1:0] out_data_r, out_data_nxt;
  logic [STATUS_W-1:0]      out_status_r, out_status_nxt;

  logic acc;
  logic out_free;
  logic qok_in;
  logic fh_ok;
  logic head_ok;
  logic tail_ok;

  // queue pointer memory port
  logic             qp_rd_en;
  logic [PTR_W-1:0] qp_head;
  logic [PTR_W-1:0] qp_tail;
  logic             qp_we;
  logic [PTR_W-1:0] qp_whead;
  logic [PTR_W-1:0] qp_wtail;

  // slot store port
  logic                     sl_rd_en;
  logic [SLOT_W-1:0]        sl_rd_addr;
  logic [PTR_W-1:0]         sl_link;
  logic signed [DATA_W-1:0] sl_data;
  logic                     sl_claim;
  logic                     sl_link_we;
  logic [SLOT_W-1:0]        sl_link_waddr;
  logic [PTR_W-1:0]         sl_link_wdata;
  logic                     sl_data_we;

  assign in_stall = (state_r != S_IDLE);
  assign acc      = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign qok_in   = ({1'b0, in_queue_id} < QUEUES_V);
  assign fh_ok    = (free_head_r < NIL);
  assign head_ok  = qok_r && (qp_head < NIL);
  assign tail_ok  = (qp_tail < NIL);

  // read the addressed queue's pointers as the transaction is taken
  assign qp_rd_en = acc && qok_in;

  mqsb_qptr_mem #(
    .QUEUES (QUEUES),
    .PTR_W  (PTR_W),
    .QID_W  (QID_W),
    .DEPTH  (DEPTH)
  ) u_qptr (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (qp_rd_en),
    .rd_addr (in_queue_id),
    .head_rd (qp_head),
    .tail_rd (qp_tail),
    .we      (qp_we),
    .waddr   (q_r),
    .whead   (qp_whead),
    .wtail   (qp_wtail)
  );

  mqsb_slot_mem #(
    .DEPTH  (DEPTH),
    .PTR_W  (PTR_W),
    .SLOT_W (SLOT_W)
  ) u_slot (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (sl_rd_en),
    .rd_addr    (sl_rd_addr),
    .link_rd    (sl_link),
    .data_rd    (sl_data),
    .claim_en   (sl_claim),
    .claim_slot (free_head_r[SLOT_W-1:0]),
    .link_we    (sl_link_we),
    .link_waddr (sl_link_waddr),
    .link_wdata (sl_link_wdata),
    .data_we    (sl_data_we),
    .data_waddr (free_head_r[SLOT_W-1:0]),
    .data_wdata (word_r)
  );

  // --------------------------------------------------------------------------
  // Sequencer. The tail slot's link is never written null on an enqueue:
  // a dequeue spots the last entry by comparing the head with the tail,
  // which keeps the link store down to one write per transaction.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    free_head_nxt  = free_head_r;
    h_nxt          = h_r;
    t_nxt          = t_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    qp_we          = 1'b0;
    qp_whead       = qp_head;
    qp_wtail       = qp_tail;
    sl_rd_en       = 1'b0;
    sl_rd_addr     = free_head_r[SLOT_W-1:0];
    sl_claim       = 1'b0;
    sl_link_we     = 1'b0;
    sl_link_waddr  = qp_tail[SLOT_W-1:0];
    sl_link_wdata  = free_head_r;
    sl_data_we     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          // fetch the free-list successor alongside the queue pointers
          sl_rd_en  = (in_func == FUNC_ENQ) && fh_ok;
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (func_r == FUNC_ENQ) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = '0;
            if (qok_r && fh_ok) begin
              out_status_nxt = STAT_OK;
              free_head_nxt  = sl_link;
              sl_claim       = 1'b1;
              sl_data_we     = 1'b1;
              qp_we          = 1'b1;
              qp_whead       = head_ok ? qp_head : free_head_r;
              qp_wtail       = free_head_r;
              // append behind the current tail
              sl_link_we     = head_ok && tail_ok;
              sl_link_waddr  = qp_tail[SLOT_W-1:0];
              sl_link_wdata  = free_head_r;
            end else begin
              out_status_nxt = STAT_OVERFLOW;
            end
            state_nxt = S_IDLE;
          end
        end else if (!head_ok) begin
          if (out_free) begin
            out_valid_nxt  = 1'b1;
            out_data_nxt   = DATA_EMPTY;
            out_status_nxt = STAT_UNDERFLOW;
            state_nxt      = S_IDLE;
          end
        end else begin
          // read the head slot's word and link
          sl_rd_en   = 1'b1;
          sl_rd_addr = qp_head[SLOT_W-1:0];
          h_nxt      = qp_head;
          t_nxt      = qp_tail;
          state_nxt  = S_DEQ;
        end
      end

      S_DEQ: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = sl_data;
          out_status_nxt = STAT_OK;
          qp_we          = 1'b1;
          qp_whead       = (h_r == t_r) ? NIL : sl_link;
          qp_wtail       = t_r;
          // push the freed slot onto the free list
          sl_link_we     = 1'b1;
          sl_link_waddr  = h_r[SLOT_W-1:0];
          sl_link_wdata  = free_head_r;
          free_head_nxt  = h_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      free_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      free_head_r <= free_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload: hold the request for the length of the transaction
  always_ff @(posedge clk) begin
    if (acc) begin
      func_r <= in_func;
      q_r    <= in_queue_id;
      word_r <= in_data_in;
      qok_r  <= qok_in;
    end
    h_r          <= h_nxt;
    t_r          <= t_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = out_data_r;
  assign out_status   = out_status_r;

endmodule : multi_queue_shared_buffer_unit

`default_nettype wire

// ----- tb/sv/multi_queue_shared_buffer_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer_unit_tb
// Self-checking bench for the shared-buffer multi-queue unit. Requests are
// driven on the input channel and mirrored in a linked-list shadow of the
// slot store, the next-slot links, the queue pointers and the free list.
// Each result transaction is checked against the oldest reply owed. Directed
// requests cover the extremes and the corner cases. Random traffic follows,
// with idling and stalls on both channels, a long output hold-off and a full
// drain pause.
// ----------------------------------------------------------------------------

module multi_queue_shared_buffer_unit_tb;

  import mqsb_pkg::*;

  localparam int DEPTH  = DEPTH_DEF;
  localparam int QUEUES = QUEUES_DEF;
  localparam int QID_W  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int PTR_W  = $clog2(DEPTH + 1);

  typedef logic [PTR_W-1:0] slot_ptr_t;

  // a slot index equal to DEPTH marks the end of a chain or an empty queue
  localparam slot_ptr_t NIL_SLOT = slot_ptr_t'(DEPTH);

  typedef struct {
    logic signed [DATA_W-1:0] data;
    logic [STATUS_W-1:0]      status;
  } reply_t;

  // --------------------------------------------------------------------------
  // DUT hookup
  // --------------------------------------------------------------------------
  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_func;
  logic [QID_W-1:0]         in_queue_id;
  logic signed [DATA_W-1:0] in_data_in;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_data_out;
  logic [STATUS_W-1:0]      out_status;

  multi_queue_shared_buffer_unit #(
    .DEPTH  (DEPTH),
    .QUEUES (QUEUES)
  ) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_func      (in_func),
    .in_queue_id  (in_queue_id),
    .in_data_in   (in_data_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_out (out_data_out),
    .out_status   (out_status)
  );

  // --------------------------------------------------------------------------
  // Shadow of the block's state: slot words, next-slot links, queue head and
  // tail pointers and the head of the free list
  // --------------------------------------------------------------------------
  logic signed [DATA_W-1:0] slot_word [DEPTH];
  slot_ptr_t                slot_next [DEPTH];
  slot_ptr_t                q_head    [QUEUES];
  slot_ptr_t                q_tail    [QUEUES];
  slot_ptr_t                free_slot;

  // replies owed by the block, oldest first
  reply_t pending_replies [$];

  int error_count   = 0;
  int checked_count = 0;
  int n_enq         = 0;
  int n_deq         = 0;
  int n_overflow    = 0;
  int n_underflow   = 0;

  // idling controls, switched by the test tasks
  bit send_idle_on = 1'b0;
  bit recv_idle_on = 1'b0;

  // long output hold-off request: flip the toggle, the stall process counts
  bit hold_toggle = 1'b0;
  int hold_len    = 0;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Far beyond the slowest clean run: ~850 transactions, each with a long
  // sender gap, a long receiver stall and the block's own processing.
  initial begin
    #10_000_000;
    $display("multi_queue_shared_buffer_unit_tb: done, errors");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Shadow update for one accepted request; returns the reply it owes
  // --------------------------------------------------------------------------
  function automatic reply_t apply_queue_op(input logic                     func,
                                            input logic [QID_W-1:0]         qid,
                                            input logic signed [DATA_W-1:0] word);
    reply_t    rep;
    slot_ptr_t s;
    rep.data   = '0;
    rep.status = STAT_OK;
    if (func == FUNC_ENQ) begin
      if (int'(qid) >= QUEUES || free_slot >= DEPTH) begin
        // no free slot or no such queue: nothing moves
        rep.status = STAT_OVERFLOW;
      end else begin
        // take the free-list head and hang it off the queue's tail
        s         = free_slot;
        free_slot = slot_next[s];
        if (q_head[qid] >= DEPTH) begin
          // empty queue: the stale tail is not followed
          q_head[qid] = s;
        end else if (q_tail[qid] < DEPTH) begin
          slot_next[q_tail[qid]] = s;
        end
        slot_next[s] = NIL_SLOT;
        q_tail[qid]  = s;
        slot_word[s] = word;
      end
    end else begin
      if (int'(qid) >= QUEUES || q_head[qid] >= DEPTH) begin
        rep.status = STAT_UNDERFLOW;
        rep.data   = DATA_EMPTY;
      end else begin
        // unlink the head slot and push it onto the free list; the tail is
        // left alone when the queue runs empty
        s            = q_head[qid];
        q_head[qid]  = (slot_next[s] < DEPTH) ? slot_next[s] : NIL_SLOT;
        slot_next[s] = free_slot;
        free_slot    = s;
        rep.data     = slot_word[s];
      end
    end
    return rep;
  endfunction

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  // idle length: mostly none or short, now and then long
  function automatic int idle_cycles(input int none_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < none_pct) return 0;
    if (r < 92)       return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // data word: the extremes turn up often, the rest is random
  function automatic logic signed [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return '0;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stall bursts, or a counted long hold-off on request
  // --------------------------------------------------------------------------
  bit hold_seen  = 1'b0;
  int hold_left  = 0;
  int burst_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_toggle != hold_seen) begin
      // start of a long hold-off: count it down here
      hold_seen <= hold_toggle;
      hold_left <= hold_len - 1;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!recv_idle_on) begin
      out_stall <= 1'b0;
    end else if (burst_left > 0) begin
      // hold the current stall level until the burst runs out
      burst_left <= burst_left - 1;
    end else begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      burst_left <= idle_cycles(0);
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each accepted result with the oldest reply owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    reply_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: result with nothing owed: expected none, actual data %0d status %0d",
                 $time, out_data_out, out_status);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        checked_count++;
        if (out_data_out !== want.data) begin
          $display("%0t: data_out mismatch: expected %0d, actual %0d",
                   $time, want.data, out_data_out);
          error_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, out_status);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender: offer one request, hold it until accepted, then log its reply
  // --------------------------------------------------------------------------
  task automatic send_request(input logic                     func,
                              input logic [QID_W-1:0]         qid,
                              input logic signed [DATA_W-1:0] word);
    int     gap;
    reply_t rep;
    gap = send_idle_on ? idle_cycles(55) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    in_func     <= func;
    in_queue_id <= qid;
    in_data_in  <= word;
    // the payload stays put while the block stalls it
    @(posedge clk);
    while (in_stall) @(posedge clk);
    rep = apply_queue_op(func, qid, word);
    pending_replies.push_back(rep);
    if (func == FUNC_ENQ) n_enq++;
    else                  n_deq++;
    if (rep.status == STAT_OVERFLOW)  n_overflow++;
    if (rep.status == STAT_UNDERFLOW) n_underflow++;
  endtask

  task automatic drop_valid();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // hold the sender until every reply owed has come back
  task automatic wait_for_replies();
    drop_valid();
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // random traffic; enq_pct biases the mix, focus_q >= 0 favours one queue
  task automatic run_random_requests(input int count, input int enq_pct,
                                     input int focus_q);
    logic             func;
    logic [QID_W-1:0] qid;
    repeat (count) begin
      func = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
      if (focus_q >= 0 && $urandom_range(0, 1) == 1) qid = QID_W'(focus_q);
      else qid = QID_W'($urandom_range(0, QUEUES - 1));
      send_request(func, qid, pick_word());
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // every queue is empty out of reset: each dequeue underflows with -1
  task automatic test_empty_queues();
    for (int q = 0; q < QUEUES; q++) send_request(FUNC_DEQ, QID_W'(q), $urandom);
  endtask

  // fill all slots with extreme words, one queue taking most of them, then
  // enqueue once more into a full buffer
  task automatic test_full_buffer();
    logic signed [DATA_W-1:0] fill_words [16];
    logic [QID_W-1:0]         qid;
    fill_words = '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, -32'sd1,
                   32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0000_0001, 32'shfffe_ffff,
                   32'sh0f0f_0f0f, 32'shf0f0_f0f0, 32'sh1234_5678, 32'sh8765_4321,
                   32'sh7fff_0000, 32'sh0000_8000, 32'sh00ff_ff00, 32'shff00_00ff};
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0)               qid = '0;
      else if (i == 7)          qid = QID_W'(2);
      else if (i == DEPTH - 1)  qid = QID_W'(QUEUES - 1);
      else                      qid = QID_W'(1);
      send_request(FUNC_ENQ, qid, fill_words[i % 16]);
    end
    send_request(FUNC_ENQ, QID_W'(QUEUES - 1), 32'sh0bad_0bad);
  endtask

  // take the last entry of a queue, dequeue it once more while empty, then
  // refill it so the stale tail is never followed
  task automatic test_requeue_after_empty();
    send_request(FUNC_DEQ, '0, $urandom);
    send_request(FUNC_DEQ, '0, $urandom);
    send_request(FUNC_ENQ, '0, 32'sh6666_9999);
    send_request(FUNC_DEQ, '0, $urandom);
  endtask

  task automatic test_mixed_traffic();
    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    run_random_requests(250, 50, -1);
  endtask

  // enqueue-heavy: drive the buffer full and into overflow, deep on one queue
  task automatic test_fill_pressure();
    run_random_requests(150, 75, $urandom_range(0, QUEUES - 1));
  endtask

  // dequeue-heavy: run the queues dry and into underflow
  task automatic test_drain_pressure();
    run_random_requests(150, 25, -1);
  endtask

  // hold the output off for a long stretch while requests keep coming, so
  // the result register fills and the block stalls its input
  task automatic test_output_backpressure();
    send_idle_on = 1'b0;
    hold_len     = 60;
    hold_toggle  = ~hold_toggle;
    run_random_requests(20, 60, -1);
  endtask

  // pause the sender until every reply is back, then resume
  task automatic test_pause_until_drained();
    send_idle_on = 1'b1;
    run_random_requests(10, 60, -1);
    wait_for_replies();
    run_random_requests(10, 40, -1);
  endtask

  // back-to-back transactions with no idling on either side
  task automatic test_streaming();
    send_idle_on = 1'b0;
    recv_idle_on = 1'b0;
    run_random_requests(200, 50, -1);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_valid    = 1'b0;
    in_func     = FUNC_ENQ;
    in_queue_id = '0;
    in_data_in  = '0;
    rst_n       = 1'b0;

    // shadow reset: slot i links to i+1, every queue empty, free list at 0
    for (int i = 0; i < DEPTH; i++) begin
      slot_word[i] = '0;
      slot_next[i] = slot_ptr_t'(i + 1);
    end
    for (int q = 0; q < QUEUES; q++) begin
      q_head[q] = NIL_SLOT;
      q_tail[q] = NIL_SLOT;
    end
    free_slot = '0;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_queues();
    test_full_buffer();
    test_requeue_after_empty();
    test_mixed_traffic();
    test_fill_pressure();
    test_drain_pressure();
    test_output_backpressure();
    test_pause_until_drained();
    test_streaming();

    // let the last results out, then leave the clock running for strays
    wait_for_replies();
    repeat (10) @(posedge clk);

    $display("Covered %0d enqueues and %0d dequeues, %0d overflows and %0d underflows,",
             n_enq, n_deq, n_overflow, n_underflow);
    $display("with %0d results checked under idling, stalls and a long hold-off.",
             checked_count);
    if (error_count == 0) begin
      $display("multi_queue_shared_buffer_unit_tb: done, clean");
    end else begin
      $display("multi_queue_shared_buffer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule
